// ----- sv/mqsb_pkg.sv -----
// shared types and codes for the multi-queue shared buffer
// no dependencies
package mqsb_pkg;

   localparam int NUM_SLOTS_DEF  = 16;
   localparam int NUM_QUEUES_DEF = 4;
   localparam int DATA_WIDTH_DEF = 32;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic               op;
      logic [1:0]         queue_id;
      logic signed [31:0] data_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data_out;
      logic [1:0]         status;
   } rsp_type;

endpackage

// ----- sv/mqsb_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module mqsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/multi_queue_shared_buffer.sv -----
// multi-queue shared buffer: fifo queues chained through one slot store
// enqueue or refused beat: state S_ENQ or S_FIN, then the result register; dequeue: S_DEQ_RD (queue table
// read), then S_DEQ (dependent slot read), then the result register; next beat taken back in S_IDLE
// a second result waiting behind an untaken one holds req_ready low until rsp_ready
// reset: the link memory is swept slot by slot to its initial free chain, req_ready low
// depends on mqsb_pkg and mqsb_ram
module multi_queue_shared_buffer #(
   parameter int NUM_SLOTS  = mqsb_pkg::NUM_SLOTS_DEF,
   parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF,
   parameter int DATA_WIDTH = mqsb_pkg::DATA_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mqsb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mqsb_pkg::rsp_type rsp_data
);

   import mqsb_pkg::*;

   localparam int SW  = $clog2(NUM_SLOTS);
   localparam int LW  = $clog2(NUM_SLOTS + 1);
   localparam int QAW = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;

   localparam logic [LW-1:0] LINK_NULL = LW'(NUM_SLOTS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ENQ    = 3'd1;
   localparam logic [2:0] S_DEQ_RD = 3'd2;
   localparam logic [2:0] S_DEQ    = 3'd3;
   localparam logic [2:0] S_FIN    = 3'd4;
   localparam logic [2:0] S_HOLD   = 3'd5;

   typedef struct packed {
      logic [SW-1:0] head;
      logic [SW-1:0] tail;
   } qent_type;

   logic [2:0]            state_ff, state_in;
   req_type               req_ff, req_in;
   logic [1:0]            st_ff, st_in;
   logic [LW-1:0]         free_ff, free_in;
   logic [NUM_QUEUES-1:0] busy_ff, busy_in;
   logic                  clr_ff, clr_in;
   logic [SW-1:0]         cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   rsp_type               hold_ff, hold_in;

   logic                  qt_wr_en, qt_rd_en;
   logic [QAW-1:0]        qt_wr_addr, qt_rd_addr;
   qent_type              qt_wr_data, qt_rd_data;
   logic                  ln_wr_en, ln_rd_en;
   logic [SW-1:0]         ln_wr_addr, ln_rd_addr;
   logic [LW-1:0]         ln_wr_data, ln_rd_data;
   logic                  dt_wr_en, dt_rd_en;
   logic [SW-1:0]         dt_wr_addr, dt_rd_addr;
   logic [DATA_WIDTH-1:0] dt_wr_data, dt_rd_data;

   logic                  accept, rsp_free, fin, in_range;
   logic [QAW-1:0]        req_q, cur_q;
   rsp_type               res;

   mqsb_ram #(.WIDTH(2 * SW), .DEPTH(NUM_QUEUES)) u_qtable (
      .clock   (clock),
      .wr_en   (qt_wr_en),
      .wr_addr (qt_wr_addr),
      .wr_data (qt_wr_data),
      .rd_en   (qt_rd_en),
      .rd_addr (qt_rd_addr),
      .rd_data (qt_rd_data)
   );

   mqsb_ram #(.WIDTH(LW), .DEPTH(NUM_SLOTS)) u_link (
      .clock   (clock),
      .wr_en   (ln_wr_en),
      .wr_addr (ln_wr_addr),
      .wr_data (ln_wr_data),
      .rd_en   (ln_rd_en),
      .rd_addr (ln_rd_addr),
      .rd_data (ln_rd_data)
   );

   mqsb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_SLOTS)) u_data (
      .clock   (clock),
      .wr_en   (dt_wr_en),
      .wr_addr (dt_wr_addr),
      .wr_data (dt_wr_data),
      .rd_en   (dt_rd_en),
      .rd_addr (dt_rd_addr),
      .rd_data (dt_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE) && !clr_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_q     = QAW'(req_data.queue_id);
   assign cur_q     = QAW'(req_ff.queue_id);
   assign in_range  = 32'(req_data.queue_id) < NUM_QUEUES;

   always_comb begin
      res.data_out = (state_ff == S_DEQ) ? 32'(dt_rd_data) : 32'sd0;
      res.status   = st_ff;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      st_in        = st_ff;
      free_in      = free_ff;
      busy_in      = busy_ff;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      hold_in      = hold_ff;
      fin          = 1'b0;
      qt_wr_en     = 1'b0;
      qt_wr_addr   = cur_q;
      qt_wr_data   = qt_rd_data;
      qt_rd_en     = 1'b0;
      qt_rd_addr   = req_q;
      ln_wr_en     = 1'b0;
      ln_wr_addr   = cnt_ff;
      ln_wr_data   = LW'(cnt_ff) + LW'(1);
      ln_rd_en     = 1'b0;
      ln_rd_addr   = free_ff[SW-1:0];
      dt_wr_en     = 1'b0;
      dt_wr_addr   = free_ff[SW-1:0];
      dt_wr_data   = DATA_WIDTH'($unsigned(req_ff.data_in));
      dt_rd_en     = 1'b0;
      dt_rd_addr   = qt_rd_data.head;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               st_in  = ST_OK;
               priority if (!in_range) begin
                  st_in    = (req_data.op == OP_DEQ) ? ST_UNDERFLOW : ST_OVERFLOW;
                  state_in = S_FIN;
               end else if (req_data.op == OP_ENQ) begin
                  if (free_ff >= LINK_NULL) begin
                     st_in    = ST_OVERFLOW;
                     state_in = S_FIN;
                  end else begin
                     qt_rd_en = 1'b1;
                     ln_rd_en = 1'b1;
                     state_in = S_ENQ;
                  end
               end else begin
                  if (!busy_ff[req_q]) begin
                     st_in    = ST_UNDERFLOW;
                     state_in = S_FIN;
                  end else begin
                     qt_rd_en = 1'b1;
                     state_in = S_DEQ_RD;
                  end
               end
            end
         end
         S_ENQ: begin
            fin        = 1'b1;
            free_in    = ln_rd_data;
            qt_wr_en   = 1'b1;
            dt_wr_en   = 1'b1;
            if (busy_ff[cur_q]) begin
               qt_wr_data.head = qt_rd_data.head;
               qt_wr_data.tail = free_ff[SW-1:0];
               ln_wr_en        = 1'b1;
               ln_wr_addr      = qt_rd_data.tail;
               ln_wr_data      = free_ff;
            end else begin
               qt_wr_data.head = free_ff[SW-1:0];
               qt_wr_data.tail = free_ff[SW-1:0];
               busy_in[cur_q]  = 1'b1;
            end
         end
         S_DEQ_RD: begin
            ln_rd_en   = 1'b1;
            ln_rd_addr = qt_rd_data.head;
            dt_rd_en   = 1'b1;
            state_in   = S_DEQ;
         end
         S_DEQ: begin
            fin        = 1'b1;
            ln_wr_en   = 1'b1;
            ln_wr_addr = qt_rd_data.head;
            ln_wr_data = free_ff;
            free_in    = LW'(qt_rd_data.head);
            if (qt_rd_data.head == qt_rd_data.tail) begin
               busy_in[cur_q] = 1'b0;
            end else begin
               qt_wr_en        = 1'b1;
               qt_wr_data.head = ln_rd_data[SW-1:0];
               qt_wr_data.tail = qt_rd_data.tail;
            end
         end
         S_FIN: begin
            fin = 1'b1;
         end
         S_HOLD: begin
            if (rsp_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         if (rsp_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            hold_in  = res;
            state_in = S_HOLD;
         end
      end

      // initial free chain: each slot links to the next
      if (clr_ff) begin
         ln_wr_en   = 1'b1;
         ln_wr_addr = cnt_ff;
         ln_wr_data = LW'(cnt_ff) + LW'(1);
         if (cnt_ff == LAST_SLOT) begin
            clr_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_ff      <= '0;
         busy_ff      <= '0;
         clr_ff       <= 1'b1;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         busy_ff      <= busy_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      st_ff   <= st_in;
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for multi_queue_shared_buffer: directed and random enqueue and
// dequeue traffic, checked beat by beat against a queue and free-list model kept here
// depends on mqsb_pkg and the multi_queue_shared_buffer rtl
`timescale 1ns / 100ps

module tb_top;
   import mqsb_pkg::*;

   localparam int SLOTS       = NUM_SLOTS_DEF;
   localparam int QUEUES      = NUM_QUEUES_DEF;
   localparam int CYCLE_LIMIT = 200000;

   typedef logic [4:0] link_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   multi_queue_shared_buffer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // shadow copy of the slot store, queue chains and free list
   logic [31:0] slot_word [SLOTS];
   link_type    slot_next [SLOTS];
   link_type    q_first   [QUEUES];
   link_type    q_last    [QUEUES];
   link_type    free_first;
   int          stored_total;

   rsp_type awaited_results [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int cycle_count    = 0;
   int error_count    = 0;
   int beats_sent     = 0;
   int ok_seen        = 0;
   int overflow_seen  = 0;
   int underflow_seen = 0;

   task automatic clear_queue_model();
      for (int i = 0; i < SLOTS; i++) begin
         slot_word[i] = '0;
         slot_next[i] = link_type'(i + 1);
      end
      for (int q = 0; q < QUEUES; q++) begin
         q_first[q] = link_type'(SLOTS);
         q_last[q]  = '0;
      end
      free_first   = '0;
      stored_total = 0;
   endtask

   function automatic rsp_type apply_queue_op(req_type beat);
      rsp_type  r;
      link_type s;
      int       q;
      r.data_out = '0;
      r.status   = ST_OK;
      q = int'(beat.queue_id);
      if (q >= QUEUES) begin
         r.status = (beat.op == OP_DEQ) ? ST_UNDERFLOW : ST_OVERFLOW;
      end else if (beat.op == OP_ENQ) begin
         if (free_first >= SLOTS) begin
            r.status = ST_OVERFLOW;
         end else begin
            s          = free_first;
            free_first = slot_next[s];
            if (q_first[q] >= SLOTS) begin
               q_first[q] = s;
            end else if (q_last[q] < SLOTS) begin
               slot_next[q_last[q]] = s;
            end
            slot_next[s] = link_type'(SLOTS);
            q_last[q]    = s;
            slot_word[s] = beat.data_in;
            stored_total++;
         end
      end else begin
         if (q_first[q] >= SLOTS) begin
            r.status = ST_UNDERFLOW;
         end else begin
            s            = q_first[q];
            q_first[q]   = slot_next[s];
            slot_next[s] = free_first;
            free_first   = s;
            r.data_out   = slot_word[s];
            stored_total--;
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic note_error(input string what, input logic [31:0] want, input logic [31:0] got);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
   endtask

   // one beat on the request channel, predicted at the edge it is taken
   task automatic send_beat(input req_type beat);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      awaited_results.push_back(apply_queue_op(beat));
      beats_sent++;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_op(input logic op, input int q, input logic [31:0] word);
      req_type beat;
      beat.op       = op;
      beat.queue_id = 2'(q);
      beat.data_in  = word;
      send_beat(beat);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            note_error("unexpected beat", '0, rsp_data.data_out);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_data.data_out !== want.data_out)
               note_error("data_out", want.data_out, rsp_data.data_out);
            if (rsp_data.status !== want.status)
               note_error("status", 32'(want.status), 32'(rsp_data.status));
            case (want.status)
               ST_OK:        ok_seen++;
               ST_OVERFLOW:  overflow_seen++;
               default:      underflow_seen++;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                  awaited_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   task automatic test_empty_queues();
      for (int q = 0; q < QUEUES; q++) send_op(OP_DEQ, q, $urandom);
   endtask

   task automatic test_data_extremes();
      send_op(OP_ENQ, 0, 32'h8000_0000);
      send_op(OP_ENQ, 1, 32'h7FFF_FFFF);
      send_op(OP_ENQ, 2, 32'hFFFF_FFFF);
      send_op(OP_ENQ, 3, 32'h0000_0000);
      send_op(OP_ENQ, 0, 32'hAAAA_AAAA);
      send_op(OP_ENQ, 0, 32'h5555_5555);
      repeat (3) send_op(OP_DEQ, 0, $urandom);
      for (int q = 1; q < QUEUES; q++) send_op(OP_DEQ, q, $urandom);
   endtask

   // fill the whole store until it refuses twice, then empty every queue and dequeue once more
   task automatic test_full_store();
      int refusals;
      refusals = 0;
      while (refusals < 2) begin
         if (stored_total == SLOTS) refusals++;
         send_op(OP_ENQ, $urandom_range(QUEUES - 1), random_word());
      end
      for (int q = 0; q < QUEUES; q++) begin
         while (q_first[q] < SLOTS) send_op(OP_DEQ, q, $urandom);
      end
      send_op(OP_DEQ, $urandom_range(QUEUES - 1), $urandom);
   endtask

   // occupancy swings between empty and full; most dequeues aim at a loaded queue
   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int beats);
      bit   filling;
      logic op;
      int   q;
      int   start;
      filling = 1'b1;
      set_idling(send_pct, recv_pct);
      repeat (beats) begin
         if (stored_total == SLOTS && $urandom_range(2) == 0) filling = 1'b0;
         else if (stored_total == 0 && $urandom_range(2) == 0) filling = 1'b1;
         else if ($urandom_range(19) == 0) filling = !filling;
         op = ($urandom_range(99) < (filling ? 80 : 20)) ? OP_ENQ : OP_DEQ;
         q  = $urandom_range(QUEUES - 1);
         if (op == OP_DEQ && $urandom_range(3) != 0) begin
            start = q;
            for (int i = 0; i < QUEUES; i++) begin
               if (q_first[(start + i) % QUEUES] < SLOTS && q == start)
                  q = (start + i) % QUEUES;
            end
         end
         send_op(op, q, random_word());
      end
   endtask

   initial begin
      clear_queue_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      set_idling(0, 0);
      test_empty_queues();
      test_data_extremes();
      test_full_store();
      test_random_traffic(0, 0, 105);
      test_random_traffic(77, 0, 105);
      test_random_traffic(0, 77, 105);
      test_random_traffic(6, 6, 105);
      wait_drained();
      $display("%0d beats sent: %0d ok, %0d overflow, %0d underflow responses",
               beats_sent, ok_seen, overflow_seen, underflow_seen);
      $display("idling phases: none, sender 77%%, receiver 77%%, both 6%%; %0d errors",
               error_count);
      if (error_count == 0 && awaited_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
